### rtl/bsc_pkg.sv
// Shared types and constants for the barometric compensation block.
// Used by bsc_ctrl, bsc_dp and baro_sensor_compensation.
`default_nettype none
package bsc_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] REG_CAL_A = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CAL_B = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CAL_C = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_OSS   = 2'd3;

	localparam logic [1:0] OSS_RESET = 2'd2;

	// datapath micro-operations, one per controller step
	typedef enum logic [4:0] {
		OP_NOP,
		OP_T1, OP_T2, OP_T3, OP_TDIV, OP_T5,
		OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7, OP_P8, OP_P9,
		OP_PDIV, OP_Q1, OP_Q2, OP_Q3, OP_Q4, OP_Q5
	} dp_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT_DIV,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   load;    // capture input beat
		logic   div_go;  // start divider
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_zero;  // divisor of the current step is zero
	} dp_stat_t;

endpackage
`default_nettype wire

### rtl/bsc_div.sv
// Iterative 32-bit unsigned divider, one quotient bit per cycle.
// Used by bsc_dp for both the temperature and pressure divisions.
`default_nettype none
module bsc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [31:0]      quotient
);
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### rtl/bsc_dp.sv
// Compensation datapath: calibration registers, B5 store, working registers,
// one multiplier and the shared divider. Depends on bsc_pkg and bsc_div.
`default_nettype none
module bsc_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bsc_pkg::CfgIdxW-1:0]    cfg_idx,
	input  wire logic [bsc_pkg::CfgDataW-1:0]   cfg_data,
	input  wire bsc_pkg::dp_cmd_t               dp_cmd,
	input  wire logic                           in_cmd,
	input  wire logic [23:0]                    in_raw,
	output bsc_pkg::dp_stat_t                   stat,
	output logic                                res_kind,
	output logic signed [31:0]                  res_value,
	output logic                                res_err
);
	import bsc_pkg::*;

	logic [63:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;
	logic signed [31:0] b5_q;

	logic        kind_q, err_q;
	logic [23:0] raw_q;
	logic signed [31:0] a_q, b_q, c_q, d_q, e_q;  // working registers

	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac4, ac5, ac6;
	assign ac1 = 32'(signed'(cal_a_q[63:48]));
	assign ac2 = 32'(signed'(cal_a_q[47:32]));
	assign ac3 = 32'(signed'(cal_a_q[31:16]));
	assign ac4 = {16'd0, cal_a_q[15:0]};
	assign ac5 = {16'd0, cal_b_q[63:48]};
	assign ac6 = {16'd0, cal_b_q[47:32]};
	assign b1  = 32'(signed'(cal_b_q[31:16]));
	assign b2  = 32'(signed'(cal_b_q[15:0]));
	assign mc  = 32'(signed'(cal_c_q[31:16]));
	assign md  = 32'(signed'(cal_c_q[15:0]));

	// multiplier operands chosen per step; only the low word is kept
	logic signed [31:0] mul_a, mul_b, mul_p;
	assign mul_p = mul_a * mul_b;

	// divider with sign handling
	logic        div_busy;
	logic [31:0] div_q, dvd_u, dvs_u;
	logic signed [31:0] dvd_s, dvs_s;
	logic        signed_div, neg_q;

	bsc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dp_cmd.div_go),
		.dividend(dvd_u), .divisor(dvs_u), .busy(div_busy), .quotient(div_q)
	);

	// temperature: (MC<<11)/den signed; pressure: b7*2/b4 or b7/b4 unsigned
	always_comb begin
		signed_div = (kind_q == 1'b0);
		dvd_s = mc <<< 11;
		dvs_s = c_q;
		if (signed_div) begin
			dvd_u = dvd_s[31] ? 32'(-dvd_s) : dvd_s;
			dvs_u = dvs_s[31] ? 32'(-dvs_s) : dvs_s;
		end else begin
			dvd_u = (d_q[31]) ? d_q : (d_q << 1);
			dvs_u = c_q;
		end
	end

	logic signed [31:0] div_res;
	assign div_res = neg_q ? 32'(-div_q) : div_q;

	// p straight from the divider: doubled afterwards when b7 had its top bit set
	logic signed [31:0] p_div;
	assign p_div = d_q[31] ? (div_q << 1) : div_q;

	logic signed [31:0] up, b6;
	assign up = 32'(raw_q >> (4'd8 - {2'b0, oss_q}));
	assign b6 = b5_q - 32'sd4000;

	// truncating divide by 4 and 16
	function automatic logic signed [31:0] sdiv4(input logic signed [31:0] v);
		return (v + (v[31] ? 32'sd3 : 32'sd0)) >>> 2;
	endfunction
	function automatic logic signed [31:0] sdiv16(input logic signed [31:0] v);
		return (v + (v[31] ? 32'sd15 : 32'sd0)) >>> 4;
	endfunction

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (dp_cmd.op)
			OP_T1: begin mul_a = 32'({8'd0, raw_q[23:8]}) - ac6; mul_b = ac5; end
			OP_P1: begin mul_a = b6; mul_b = b6; end
			OP_P2: begin mul_a = b2; mul_b = a_q; end
			OP_P3: begin mul_a = ac2; mul_b = b6; end
			OP_P5: begin mul_a = ac3; mul_b = b6; end
			OP_P6: begin mul_a = b1; mul_b = a_q; end
			OP_P7: begin mul_a = ac4; mul_b = c_q + 32'sd32768; end
			OP_P8: begin mul_a = up - b_q; mul_b = 32'(32'd50000 >> oss_q); end
			OP_Q1: begin mul_a = p_div >>> 8; mul_b = p_div >>> 8; end
			OP_Q2: begin mul_a = b_q; mul_b = 32'sd3038; end
			OP_Q3: begin mul_a = -32'sd7357; mul_b = a_q; end
			default: ;
		endcase
	end

	// temperature: a=x1, c=den, b=b5.  pressure: a=sq, b=b3, c=x3/b4, d=b7
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			kind_q <= in_cmd;
			raw_q  <= in_raw;
			err_q  <= 1'b0;
		end
		unique case (dp_cmd.op)
			OP_T1: a_q <= mul_p >>> 15;
			OP_T2: c_q <= a_q + md;
			OP_T3: begin
				neg_q <= dvd_s[31] ^ c_q[31];
				err_q <= (c_q == 0);
			end
			OP_T5: begin
				b_q <= a_q + div_res;
				e_q <= sdiv16(a_q + div_res + 32'sd8);
			end
			OP_P1: a_q <= mul_p >>> 12;
			OP_P2: e_q <= mul_p >>> 11;
			OP_P3: e_q <= e_q + (mul_p >>> 11);
			OP_P4: b_q <= sdiv4(((ac1 * 4 + e_q) << oss_q) + 32'sd2);
			OP_P5: e_q <= mul_p >>> 13;
			OP_P6: c_q <= sdiv4(e_q + (mul_p >>> 16) + 32'sd2);
			OP_P7: c_q <= 32'(unsigned'(mul_p) >> 15);
			OP_P8: d_q <= mul_p;
			OP_P9: begin
				neg_q <= 1'b0;
				err_q <= (c_q == 0);
			end
			OP_Q1: begin
				a_q <= p_div;
				b_q <= mul_p;
			end
			OP_Q2: b_q <= mul_p >>> 16;
			OP_Q3: b_q <= b_q + (mul_p >>> 16);
			OP_Q4: e_q <= a_q + sdiv16(b_q + 32'sd3791);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= OSS_RESET;
			b5_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_CAL_A: cal_a_q <= cfg_data;
					REG_CAL_B: cal_b_q <= cfg_data;
					REG_CAL_C: cal_c_q <= cfg_data[31:0];
					REG_OSS:   oss_q   <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (dp_cmd.op == OP_T5 && !err_q) begin
				b5_q <= a_q + div_res;
			end
		end
	end

	assign stat.div_busy = div_busy;
	assign stat.div_zero = err_q;
	assign res_kind  = kind_q;
	assign res_err   = err_q;
	assign res_value = err_q ? 32'sd0 : e_q;
endmodule
`default_nettype wire

### rtl/bsc_ctrl.sv
// Sequencer for the compensation datapath: steps through micro-operations,
// waits on the divider, holds the result beat. Depends on bsc_pkg.
`default_nettype none
module bsc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_cmd,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire bsc_pkg::dp_stat_t stat,
	output bsc_pkg::dp_cmd_t       dp_cmd
);
	import bsc_pkg::*;

	ctrl_state_t state_q, state_d;
	dp_op_t      op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NOP;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		dp_cmd = '{op: OP_NOP, load: 1'b0, div_go: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.load = 1'b1;
					op_d = in_cmd ? OP_P1 : OP_T1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				dp_cmd.op = op_q;
				unique case (op_q)
					OP_T3, OP_P9: begin
						// check divisor: zero means error result directly
						state_d = ST_WAIT_DIV;
						op_d = (op_q == OP_T3) ? OP_TDIV : OP_PDIV;
					end
					OP_T5, OP_Q4: state_d = ST_OUT;
					OP_T1: op_d = OP_T2;
					OP_T2: op_d = OP_T3;
					OP_P1: op_d = OP_P2;
					OP_P2: op_d = OP_P3;
					OP_P3: op_d = OP_P4;
					OP_P4: op_d = OP_P5;
					OP_P5: op_d = OP_P6;
					OP_P6: op_d = OP_P7;
					OP_P7: op_d = OP_P8;
					OP_P8: op_d = OP_P9;
					OP_Q1: op_d = OP_Q2;
					OP_Q2: op_d = OP_Q3;
					OP_Q3: op_d = OP_Q4;
					default: state_d = ST_OUT;
				endcase
			end
			ST_WAIT_DIV: begin
				if (stat.div_zero) begin
					state_d = ST_OUT;
				end else if (op_q == OP_TDIV || op_q == OP_PDIV) begin
					dp_cmd.div_go = 1'b1;
					op_d = (op_q == OP_TDIV) ? OP_T5 : OP_Q1;
				end else if (!stat.div_busy) begin
					state_d = ST_RUN;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/baro_sensor_compensation.sv
// Barometric sensor compensation, temperature and pressure.
// Each beat runs its micro-operation sequence, waits on the divider, then presents its result.
// A zero divisor skips the divider and yields an error result.
// One beat in flight; output held until taken, next input accepted the cycle after,
// so a new beat is not accepted until the result of the previous one has been taken.
// arst_n clears calibration to zero, oversampling to 2 and stored B5 to zero.
`default_nettype none
module baro_sensor_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // raw_sample[23:0]
	input  wire logic        s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // value[31:0], div_error[32], zero pad
	output logic             m_tuser    // kind
);
	import bsc_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;
	logic signed [31:0] res_value;
	logic res_err;

	// sequencer
	bsc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_cmd(s_tuser), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.stat(dp_stat), .dp_cmd(dp_cmd)
	);

	// arithmetic and calibration storage
	bsc_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.dp_cmd(dp_cmd), .in_cmd(s_tuser), .in_raw(s_tdata),
		.stat(dp_stat), .res_kind(m_tuser), .res_value(res_value), .res_err(res_err)
	);

	assign m_tdata = {7'd0, res_err, res_value};
endmodule
`default_nettype wire

### rtl/baro_sensor_compensation_chk.sv
// Port-level checker for the compensation block, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module baro_sensor_compensation_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);
	// error beats carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0) else $error("err value");
	// no input taken while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("overlap");
	// a result cannot appear the cycle after acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid) else $error("latency");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
endmodule

bind baro_sensor_compensation baro_sensor_compensation_chk u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
